[hdl/ufl_pkg.sv]
// Shared field widths, operation codes and payload types of the union-find block.
package ufl_pkg;

  localparam int FIELD_W = 12;

  typedef logic [FIELD_W-1:0] elem_t;
  typedef logic               op_t;

  localparam op_t OP_MERGE = 1'b0;
  localparam op_t OP_FIND  = 1'b1;

endpackage

[hdl/ufl_in_if.sv]
// Request channel: one merge or find item per handshake.
interface ufl_in_if import ufl_pkg::*; ();

  logic  valid;
  logic  ready;
  op_t   op;
  elem_t elem_a;
  elem_t elem_b;

  modport source (output valid, output op, output elem_a, output elem_b, input ready);
  modport sink   (input valid, input op, input elem_a, input elem_b, output ready);

endinterface

[hdl/ufl_out_if.sv]
// Result channel: representative and already-joined flag per item.
interface ufl_out_if import ufl_pkg::*; ();

  logic  valid;
  logic  ready;
  elem_t representative;
  logic  already_joined;

  modport source (output valid, output representative, output already_joined, input ready);
  modport sink   (input valid, input representative, input already_joined, output ready);

endinterface

[hdl/ufl_node_ram.sv]
// Node memory: one write port and one read port with registered read data.
module ufl_node_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/union_find_linked_classes_core.sv]
// Equivalence-class engine: merge and find over ELEMENTS elements with class lists.
//
// in_ch carries one item: op (merge or find), elem_a and elem_b. out_ch returns
// one item per request: the representative of elem_a after the operation and a
// flag set when a merge found both elements already in one class.
// All node state lives in one memory word per element (representative, link,
// link valid) behind a single read port and a single write port.
// Steps per item, from acceptance to the result being offered:
//   find                  read elem_a, then offer the result
//   merge, same class     read elem_a and elem_b, compare, then offer the result
//   merge, new class      read, compare, then rewrite each member of the absorbed class
//                         (one per cycle, set by the read-modify-write walk over the memory port)
// With ELEMENTS not a power of two and below 4096, indices are reduced modulo
// ELEMENTS by shifted conditional subtraction before the first memory read.
// One item is worked on at a time; a new item is taken while the previous result
// still sits in the output register. A stalled receiver holds the result there
// and keeps the engine from finishing the next item.
// After reset the block initializes the memory with in_ch.ready low.
module union_find_linked_classes_core import ufl_pkg::*; #(
  parameter int ELEMENTS = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  ufl_in_if.sink     in_ch,
  ufl_out_if.source  out_ch
);

  localparam int IW       = $clog2(ELEMENTS);
  localparam int WW       = 2 * IW + 1;
  localparam int CW       = IW + 1;
  localparam int KW       = $clog2(FIELD_W);
  localparam bit POW2     = (ELEMENTS == (1 << IW));
  localparam bit NEED_MOD = !POW2 && (ELEMENTS < (1 << FIELD_W));
  localparam int MOD_TOP  = NEED_MOD ? FIELD_W - IW : 0;

  localparam logic [FIELD_W-1:0] EMOD     = FIELD_W'(ELEMENTS);
  localparam logic [CW-1:0]      STEP_MAX = CW'(ELEMENTS);
  localparam logic [IW-1:0]      LAST_IDX = IW'(ELEMENTS - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_RDA  = 3'd3;
  localparam logic [2:0] S_RDB  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_WALK = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [IW-1:0]      clr_r, clr_nxt;
  op_t                op_r, op_nxt;
  elem_t              a_val_r, a_val_nxt;
  elem_t              b_val_r, b_val_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [WW-1:0]      word_a_r, word_a_nxt;
  logic [IW-1:0]      cur_r, cur_nxt;
  logic [IW-1:0]      newroot_r, newroot_nxt;
  logic [IW-1:0]      keep_link_r, keep_link_nxt;
  logic               keep_valid_r, keep_valid_nxt;
  logic [CW-1:0]      steps_r, steps_nxt;
  logic [IW-1:0]      rep_r, rep_nxt;
  logic               joined_r, joined_nxt;
  logic               out_valid_r, out_valid_nxt;
  elem_t              out_rep_r, out_rep_nxt;
  logic               out_joined_r, out_joined_nxt;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [WW-1:0]      mem_wdata;
  logic [IW-1:0]      mem_raddr;
  logic [WW-1:0]      rd_data;

  logic [IW-1:0]      a_idx, b_idx;
  logic [IW-1:0]      rd_root, rd_link, wa_root, wa_link;
  logic               rd_lv, wa_lv;
  logic [FIELD_W-1:0] mod_div;
  logic               cmp_swap;
  logic [IW-1:0]      cmp_addr, cmp_newroot, cmp_cur, cmp_link;
  logic               cmp_lv;

  ufl_node_ram #(
    .DEPTH (ELEMENTS),
    .WIDTH (WW)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign a_idx   = IW'(a_val_r);
  assign b_idx   = IW'(b_val_r);
  assign rd_root = rd_data[WW-1 -: IW];
  assign rd_lv   = rd_data[IW];
  assign rd_link = rd_data[IW-1:0];
  assign wa_root = word_a_r[WW-1 -: IW];
  assign wa_lv   = word_a_r[IW];
  assign wa_link = word_a_r[IW-1:0];
  assign mod_div = EMOD << k_r;

  assign cmp_swap    = wa_root > rd_root;
  assign cmp_addr    = cmp_swap ? b_idx : a_idx;
  assign cmp_newroot = cmp_swap ? rd_root : wa_root;
  assign cmp_cur     = cmp_swap ? wa_root : rd_root;
  assign cmp_link    = cmp_swap ? rd_link : wa_link;
  assign cmp_lv      = cmp_swap ? rd_lv : wa_lv;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.representative = out_rep_r;
  assign out_ch.already_joined = out_joined_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    a_val_nxt      = a_val_r;
    b_val_nxt      = b_val_r;
    k_nxt          = k_r;
    word_a_nxt     = word_a_r;
    cur_nxt        = cur_r;
    newroot_nxt    = newroot_r;
    keep_link_nxt  = keep_link_r;
    keep_valid_nxt = keep_valid_r;
    steps_nxt      = steps_r;
    rep_nxt        = rep_r;
    joined_nxt     = joined_r;
    out_valid_nxt  = out_valid_r;
    out_rep_nxt    = out_rep_r;
    out_joined_nxt = out_joined_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = cur_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = {clr_r, 1'b0, IW'(0)};
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.op;
          a_val_nxt = in_ch.elem_a;
          b_val_nxt = in_ch.elem_b;
          k_nxt     = KW'(MOD_TOP);
          state_nxt = NEED_MOD ? S_MOD : S_RDA;
        end
      end
      S_MOD: begin
        if (a_val_r >= mod_div) begin
          a_val_nxt = a_val_r - mod_div;
        end
        if (b_val_r >= mod_div) begin
          b_val_nxt = b_val_r - mod_div;
        end
        if (k_r == '0) begin
          state_nxt = S_RDA;
        end else begin
          k_nxt = k_r - KW'(1);
        end
      end
      S_RDA: begin
        mem_raddr = a_idx;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        word_a_nxt = rd_data;
        if (op_r == OP_FIND) begin
          rep_nxt    = rd_root;
          joined_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          mem_raddr = b_idx;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (wa_root == rd_root) begin
          rep_nxt    = wa_root;
          joined_nxt = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = cmp_addr;
          mem_wdata      = {cmp_newroot, 1'b1, cmp_cur};
          mem_raddr      = cmp_cur;
          keep_link_nxt  = cmp_link;
          keep_valid_nxt = cmp_lv;
          newroot_nxt    = cmp_newroot;
          cur_nxt        = cmp_cur;
          steps_nxt      = '0;
          rep_nxt        = cmp_newroot;
          joined_nxt     = 1'b0;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        if (rd_lv && (steps_r < STEP_MAX)) begin
          mem_wdata = {newroot_r, 1'b1, rd_link};
          mem_raddr = rd_link;
          cur_nxt   = rd_link;
          steps_nxt = steps_r + CW'(1);
        end else begin
          mem_wdata = {newroot_r, keep_valid_r, keep_link_r};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_rep_nxt    = FIELD_W'(rep_r);
          out_joined_nxt = joined_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    a_val_r      <= a_val_nxt;
    b_val_r      <= b_val_nxt;
    k_r          <= k_nxt;
    word_a_r     <= word_a_nxt;
    cur_r        <= cur_nxt;
    newroot_r    <= newroot_nxt;
    keep_link_r  <= keep_link_nxt;
    keep_valid_r <= keep_valid_nxt;
    steps_r      <= steps_nxt;
    rep_r        <= rep_nxt;
    joined_r     <= joined_nxt;
    out_rep_r    <= out_rep_nxt;
    out_joined_r <= out_joined_nxt;
  end

endmodule
